// ===== design/crt_pkg.sv =====
`timescale 1ns / 1ps

package crt_pkg;

  // Fixed field widths
  localparam int unsigned VAL_W        = 10;  // signed input value
  localparam int unsigned LEN_W        = 11;  // run length / longest
  localparam int unsigned TDATA_IN_W   = 16;
  localparam int unsigned TDATA_OUT_W  = 16;
  localparam int unsigned KEY_BITS_DEF = 10;

  // Controller -> datapath
  typedef struct packed {
    logic capture;    // load request registers
    logic clr_step;   // write zero at sweep pointer, advance it
    logic rd_c;       // read centre entry
    logic rd_l;       // read left neighbour
    logic rd_r;       // read right neighbour
    logic lat_l;      // latch left length from read data
    logic wr_l;       // latch right length, form total, write left end
    logic wr_r;       // write right end
    logic wr_c;       // write centre
    logic load_out;   // load output register
    logic out_rep;    // repeated flag for the output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic start;      // captured request asks for a clear
    logic in_range;   // value lies inside the key range
    logic has_left;   // value-1 lies inside the key range
    logic has_right;  // value+1 lies inside the key range
    logic clr_last;   // sweep pointer at last entry
    logic centre_hit; // centre entry already non-zero
    logic both_sides; // both neighbour runs non-empty
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

// ===== design/crt_ctrl.sv =====
`timescale 1ns / 1ps

module crt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  crt_pkg::sts_t sts_i,
  output crt_pkg::cmd_t cmd_o
);

  typedef enum logic [11:0] {
    ST_CLR_RST  = 12'h001,
    ST_IDLE     = 12'h002,
    ST_DISPATCH = 12'h004,
    ST_CLR_ITEM = 12'h008,
    ST_RD_C     = 12'h010,
    ST_RD_L     = 12'h020,
    ST_RD_R     = 12'h040,
    ST_WR_L     = 12'h080,
    ST_WR_R     = 12'h100,
    ST_WR_C     = 12'h200,
    ST_DONE     = 12'h400,
    ST_DONE_REP = 12'h800
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR_RST;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLR_RST: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.start) begin
          state_d = ST_CLR_ITEM;
        end else if (!sts_i.in_range) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd_c = 1'b1;
          state_d    = ST_RD_L;
        end
      end
      ST_CLR_ITEM: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_RD_C;
        end
      end
      ST_RD_C: begin
        if (!sts_i.in_range) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd_c = 1'b1;
          state_d    = ST_RD_L;
        end
      end
      ST_RD_L: begin
        if (sts_i.centre_hit) begin
          state_d = ST_DONE_REP;
        end else begin
          cmd_o.rd_l = sts_i.has_left;
          state_d    = ST_RD_R;
        end
      end
      ST_RD_R: begin
        cmd_o.lat_l = 1'b1;
        cmd_o.rd_r  = sts_i.has_right;
        state_d     = ST_WR_L;
      end
      ST_WR_L: begin
        cmd_o.wr_l = 1'b1;
        state_d    = ST_WR_R;
      end
      ST_WR_R: begin
        cmd_o.wr_r = 1'b1;
        state_d    = sts_i.both_sides ? ST_WR_C : ST_DONE;
      end
      ST_WR_C: begin
        cmd_o.wr_c = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_DONE_REP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_rep  = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLR_RST;
      end
    endcase
  end

endmodule

// ===== design/crt_dp.sv =====
`timescale 1ns / 1ps

module crt_dp #(
  parameter int unsigned KEY_BITS = crt_pkg::KEY_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic        [crt_pkg::TDATA_IN_W-1:0]  in_data_i,
  input  logic                              in_start_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic        [crt_pkg::TDATA_OUT_W-1:0] out_data_o,
  output logic                              out_rep_o,
  input  crt_pkg::cmd_t                     cmd_i,
  output crt_pkg::sts_t                     sts_o
);

  localparam int unsigned AW    = KEY_BITS;
  localparam int unsigned DEPTH = 1 << KEY_BITS;
  localparam int unsigned LW    = crt_pkg::LEN_W;
  localparam int unsigned VW    = crt_pkg::VAL_W;
  localparam int unsigned EW    = ((AW > VW) ? AW : VW) + 2;
  localparam int unsigned SW    = (AW > LW) ? AW : LW;
  localparam logic signed [EW-1:0] KEY_HALF = EW'(longint'(1) << (KEY_BITS - 1));

  // Request registers
  logic signed [VW-1:0] val_q;
  logic                 start_q;

  // Run table: read port and write port, read data registered
  logic [LW-1:0] mem [DEPTH];
  logic [LW-1:0] rdata_q;
  logic          re, we;
  logic [AW-1:0] raddr, waddr;
  logic [LW-1:0] wdata;

  logic [AW-1:0] clr_cnt_q;
  logic [LW-1:0] l_q, r_q, total_q, best_q;
  logic [LW-1:0] r_val, total_d;
  logic          out_valid_q, out_rep_q;
  logic [LW-1:0] out_len_q;

  logic signed [EW-1:0] key, idx_sum;
  logic [AW-1:0]        idx, addr_left, addr_right;
  logic [SW-1:0]        left_w, right_w;

  assign key     = EW'(val_q);
  assign idx_sum = key + KEY_HALF;
  assign idx     = idx_sum[AW-1:0];

  // Run ends, modulo the table size
  assign left_w     = SW'(idx) - SW'(l_q);
  assign right_w    = SW'(idx) + SW'(r_q);
  assign addr_left  = left_w[AW-1:0];
  assign addr_right = right_w[AW-1:0];

  assign r_val   = sts_o.has_right ? rdata_q : '0;
  assign total_d = l_q + r_val + LW'(1);

  always_comb begin
    re    = cmd_i.rd_c | cmd_i.rd_l | cmd_i.rd_r;
    raddr = idx;
    if (cmd_i.rd_l) begin
      raddr = idx - AW'(1);
    end else if (cmd_i.rd_r) begin
      raddr = idx + AW'(1);
    end
    we    = cmd_i.clr_step | cmd_i.wr_l | cmd_i.wr_r | cmd_i.wr_c;
    waddr = idx;
    wdata = total_q;
    if (cmd_i.clr_step) begin
      waddr = clr_cnt_q;
      wdata = '0;
    end else if (cmd_i.wr_l) begin
      waddr = addr_left;
      wdata = total_d;
    end else if (cmd_i.wr_r) begin
      waddr = addr_right;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      val_q <= in_data_i[VW-1:0];
    end
    if (cmd_i.lat_l) begin
      l_q <= sts_o.has_left ? rdata_q : '0;
    end
    if (cmd_i.wr_l) begin
      r_q     <= r_val;
      total_q <= total_d;
    end
    if (cmd_i.load_out) begin
      out_len_q <= best_q;
      out_rep_q <= cmd_i.out_rep;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= 1'b0;
      clr_cnt_q   <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        start_q <= in_start_i;
      end else if (cmd_i.clr_step) begin
        start_q <= 1'b0;
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        best_q    <= '0;
      end else if (cmd_i.wr_l && (total_d > best_q)) begin
        best_q <= total_d;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.start      = start_q;
    sts_o.in_range   = (key >= -KEY_HALF) && (key < KEY_HALF);
    sts_o.has_left   = key > -KEY_HALF;
    sts_o.has_right  = key < (KEY_HALF - EW'(1));
    sts_o.clr_last   = &clr_cnt_q;
    sts_o.centre_hit = (rdata_q != '0);
    sts_o.both_sides = (l_q != '0) && (r_q != '0);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = crt_pkg::TDATA_OUT_W'(out_len_q);
  assign out_rep_o   = out_rep_q;

endmodule

// ===== design/consecutive_run_tracker.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Group    tdata (low bit up)            tuser
// --------  ---  -------  ----------------------------  ------------
// request   in   s_axis   value[9:0] signed, 6 b zero   start_req
// result    out  m_axis   longest[10:0], 5 b zero       repeated
//
// A new value goes dispatch (centre read), RD_L (left read), RD_R (right
// read), WR_L, WR_R and, when it joins two runs, WR_C, then DONE; a repeat
// leaves RD_L for DONE_REP, and a value outside the key range goes straight
// to DONE. The single read port and single write port of the run table set
// this: up to three reads and two or three writes, one each per cycle.
// A set start adds a sweep over all 2^KEY_BITS entries that zeroes the
// table, then ST_RD_C to issue the centre read. After reset the same sweep
// runs before s_axis_tready rises.
// The result sits in an output register; the next request is taken while
// it waits, but a finished result stalls until the register is free.

module consecutive_run_tracker #(
  parameter int unsigned KEY_BITS = crt_pkg::KEY_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request: tdata = value, tuser = start_req
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [crt_pkg::TDATA_IN_W-1:0]     s_axis_tdata,   // value[9:0], zero pad
  input  logic                               s_axis_tuser,   // start_req
  // result: tdata = longest, tuser = repeated
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [crt_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,   // longest[10:0], zero pad
  output logic                               m_axis_tuser    // repeated
);

  crt_pkg::cmd_t cmd;
  crt_pkg::sts_t sts;

  // Sequencer: sweep, reads of centre and neighbours, end writes
  crt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Run table, length registers, running maximum, output register
  crt_dp #(
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_rep_o   (m_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
